>>> rtl/sit_pkg.sv
// Package for the segment intersection test: coordinate, difference and
// product widths, payload types. No dependencies; every other file uses it.
`timescale 1ns / 1ps

package sit_pkg;

   // Coordinate width and the widths that follow from it exactly.
   localparam int COORD_WIDTH = 16;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int SUM_WIDTH   = PROD_WIDTH + 1;
   localparam int TOTAL_WIDTH = SUM_WIDTH + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic signed [TOTAL_WIDTH-1:0] total_type;

   // One input transaction: the two segments.
   typedef struct packed {
      coord_type a_start_x;
      coord_type a_start_y;
      coord_type a_end_x;
      coord_type a_end_y;
      coord_type b_start_x;
      coord_type b_start_y;
      coord_type b_end_x;
      coord_type b_end_y;
   } seg_pair_type;

   // All pairwise products that the cross and dot products are built from.
   typedef struct packed {
      prod_type rx_sy;
      prod_type ry_sx;
      prod_type qx_sy;
      prod_type qy_sx;
      prod_type qx_ry;
      prod_type qy_rx;
      prod_type rx_rx;
      prod_type ry_ry;
      prod_type qx_rx;
      prod_type qy_ry;
      prod_type sx_rx;
      prod_type sy_ry;
   } prod_set_type;

endpackage

>>> rtl/sit_if.sv
// Channel interfaces for the segment intersection test: request (two
// segments) and response (intersection flag). Depends on sit_pkg.
`timescale 1ns / 1ps

interface sit_req_if;
   logic                valid;
   logic                ready;
   sit_pkg::coord_type a_start_x;
   sit_pkg::coord_type a_start_y;
   sit_pkg::coord_type a_end_x;
   sit_pkg::coord_type a_end_y;
   sit_pkg::coord_type b_start_x;
   sit_pkg::coord_type b_start_y;
   sit_pkg::coord_type b_end_x;
   sit_pkg::coord_type b_end_y;

   modport source (
      output valid, a_start_x, a_start_y, a_end_x, a_end_y,
             b_start_x, b_start_y, b_end_x, b_end_y,
      input  ready
   );
   modport sink (
      input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
             b_start_x, b_start_y, b_end_x, b_end_y,
      output ready
   );
endinterface

interface sit_rsp_if;
   logic valid;
   logic ready;
   logic intersects;

   modport source (output valid, intersects, input ready);
   modport sink (input valid, intersects, output ready);
endinterface

>>> rtl/sit_product_stage.sv
// Product stage: edge vectors of both segments and the twelve signed
// products behind the cross and dot products, registered. Depends on sit_pkg.
`timescale 1ns / 1ps

module sit_product_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sit_pkg::seg_pair_type in_pair,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sit_pkg::prod_set_type out_prod
);

   sit_pkg::diff_type rx, ry, sx, sy, qx, qy;
   sit_pkg::prod_set_type prod_in;
   sit_pkg::prod_set_type prod_ff;
   logic valid_in;
   logic valid_ff;

   // Edge vectors r = A end - A start, s = B end - B start, q = B start - A start.
   always_comb begin
      rx = sit_pkg::DIFF_WIDTH'(in_pair.a_end_x) - sit_pkg::DIFF_WIDTH'(in_pair.a_start_x);
      ry = sit_pkg::DIFF_WIDTH'(in_pair.a_end_y) - sit_pkg::DIFF_WIDTH'(in_pair.a_start_y);
      sx = sit_pkg::DIFF_WIDTH'(in_pair.b_end_x) - sit_pkg::DIFF_WIDTH'(in_pair.b_start_x);
      sy = sit_pkg::DIFF_WIDTH'(in_pair.b_end_y) - sit_pkg::DIFF_WIDTH'(in_pair.b_start_y);
      qx = sit_pkg::DIFF_WIDTH'(in_pair.b_start_x) - sit_pkg::DIFF_WIDTH'(in_pair.a_start_x);
      qy = sit_pkg::DIFF_WIDTH'(in_pair.b_start_y) - sit_pkg::DIFF_WIDTH'(in_pair.a_start_y);
   end

   // Twelve independent signed multiplies, each exact at full product width.
   always_comb begin
      prod_in.rx_sy = rx * sy;
      prod_in.ry_sx = ry * sx;
      prod_in.qx_sy = qx * sy;
      prod_in.qy_sx = qy * sx;
      prod_in.qx_ry = qx * ry;
      prod_in.qy_rx = qy * rx;
      prod_in.rx_rx = rx * rx;
      prod_in.ry_ry = ry * ry;
      prod_in.qx_rx = qx * rx;
      prod_in.qy_ry = qy * ry;
      prod_in.sx_rx = sx * rx;
      prod_in.sy_ry = sy * ry;
   end

   // The stage takes a new transaction when empty or when its content moves on.
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_prod  = prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
      end
   end

   // A stalled stage keeps its products.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(prod_ff))
      else $error("product stage lost or changed a stalled transaction");

endmodule

>>> rtl/sit_decide_stage.sv
// Decision stage: sums the products into cross and dot products, applies
// the non-parallel and collinear tests, registers the flag. Depends on sit_pkg.
`timescale 1ns / 1ps

module sit_decide_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sit_pkg::prod_set_type in_prod,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  out_intersects
);

   sit_pkg::sum_type   den, tnum, unum, rr, n0, sr;
   sit_pkg::total_type n1, rr_wide;
   logic t_ok, u_ok, nonpar_hit, col_hit, hit_in;
   logic valid_in;
   logic valid_ff;
   logic hit_ff;

   // num/den lies in [0,1] for nonzero den, without negating either side.
   function automatic logic ratio_ok(sit_pkg::sum_type num, sit_pkg::sum_type d);
      logic r;
      if (d > 0) begin
         r = (num >= 0) && (num <= d);
      end else begin
         r = (num <= 0) && (num >= d);
      end
      return r;
   endfunction

   // Cross products, squared length of A and the projections of B onto A.
   always_comb begin
      den     = sit_pkg::SUM_WIDTH'(in_prod.rx_sy) - sit_pkg::SUM_WIDTH'(in_prod.ry_sx);
      tnum    = sit_pkg::SUM_WIDTH'(in_prod.qx_sy) - sit_pkg::SUM_WIDTH'(in_prod.qy_sx);
      unum    = sit_pkg::SUM_WIDTH'(in_prod.qx_ry) - sit_pkg::SUM_WIDTH'(in_prod.qy_rx);
      rr      = sit_pkg::SUM_WIDTH'(in_prod.rx_rx) + sit_pkg::SUM_WIDTH'(in_prod.ry_ry);
      n0      = sit_pkg::SUM_WIDTH'(in_prod.qx_rx) + sit_pkg::SUM_WIDTH'(in_prod.qy_ry);
      sr      = sit_pkg::SUM_WIDTH'(in_prod.sx_rx) + sit_pkg::SUM_WIDTH'(in_prod.sy_ry);
      n1      = sit_pkg::TOTAL_WIDTH'(n0) + sit_pkg::TOTAL_WIDTH'(sr);
      rr_wide = sit_pkg::TOTAL_WIDTH'(rr);
   end

   // Non-parallel segments meet when both parameters lie in [0,1]. Collinear
   // segments meet when an end of B projects into A or the ends straddle A's start;
   // a zero-length A never reports a hit.
   always_comb begin
      t_ok       = ratio_ok(tnum, den);
      u_ok       = ratio_ok(unum, den);
      nonpar_hit = (den != 0) && t_ok && u_ok;
      col_hit    = (den == 0) && (unum == 0) && (rr != 0) &&
                   (((n0 >= 0) && (n0 <= rr)) ||
                    ((n1 >= 0) && (n1 <= rr_wide)) ||
                    ((n0 < 0) != (n1 < 0)));
      hit_in     = nonpar_hit || col_hit;
   end

   // Result register; it frees up when the response transaction is taken.
   assign in_ready       = !valid_ff || out_ready;
   assign valid_in       = in_ready ? in_valid : valid_ff;
   assign out_valid      = valid_ff;
   assign out_intersects = hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         hit_ff <= hit_in;
      end
   end

   // A transaction handed to this stage shows up as a result next cycle.
   assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff)
      else $error("decision stage dropped a transaction");

   // A zero-length segment A never intersects.
   assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready && (in_prod.rx_rx == 0) && (in_prod.ry_ry == 0) |=> !hit_ff)
      else $error("degenerate segment A reported as intersecting");

endmodule

>>> rtl/segment_intersection_test.sv
// Exact 2D segment intersection test, endpoints included: top level with
// the input register and the two processing stages. Depends on sit_pkg,
// sit_if, sit_product_stage and sit_decide_stage.
// From request acceptance to a valid response, a transaction passes the input
// register, which loads at the accepting edge, then the product and result registers.
// Throughput: one transaction per cycle without stalls; each slot frees when its
// content moves on, so a stalled response still lets two more requests in.
// Reset (synchronous, active high) clears the stage valid flags only.
`timescale 1ns / 1ps

module segment_intersection_test (
   input  logic clock,
   input  logic reset,
   sit_req_if.sink   req_chan,
   sit_rsp_if.source rsp_chan
);

   sit_pkg::seg_pair_type pair_in;
   sit_pkg::seg_pair_type pair_ff;
   logic pair_valid_in;
   logic pair_valid_ff;
   logic prod_ready;
   logic prod_valid;
   logic decide_ready;
   sit_pkg::prod_set_type prod;

   // Collect the request fields into one payload.
   always_comb begin
      pair_in.a_start_x = req_chan.a_start_x;
      pair_in.a_start_y = req_chan.a_start_y;
      pair_in.a_end_x   = req_chan.a_end_x;
      pair_in.a_end_y   = req_chan.a_end_y;
      pair_in.b_start_x = req_chan.b_start_x;
      pair_in.b_start_y = req_chan.b_start_y;
      pair_in.b_end_x   = req_chan.b_end_x;
      pair_in.b_end_y   = req_chan.b_end_y;
   end

   // Input register.
   assign req_chan.ready = !pair_valid_ff || prod_ready;
   assign pair_valid_in  = req_chan.ready ? req_chan.valid : pair_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
      end else begin
         pair_valid_ff <= pair_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         pair_ff <= pair_in;
      end
   end

   // Edge vectors and products.
   sit_product_stage u_product (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pair_valid_ff),
      .in_ready  (prod_ready),
      .in_pair   (pair_ff),
      .out_valid (prod_valid),
      .out_ready (decide_ready),
      .out_prod  (prod)
   );

   // Sums, comparisons and the result register.
   sit_decide_stage u_decide (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (prod_valid),
      .in_ready       (decide_ready),
      .in_prod        (prod),
      .out_valid      (rsp_chan.valid),
      .out_ready      (rsp_chan.ready),
      .out_intersects (rsp_chan.intersects)
   );

   // Intake stops only when every register slot holds a transaction.
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> pair_valid_ff && prod_valid && rsp_chan.valid)
      else $error("request refused with a free register slot");

   // A new response can only come from a transaction in the product stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(prod_valid))
      else $error("response appeared without a transaction behind it");

endmodule
